// ----- design/fpwb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_pkg: shared definitions for the flash page write-back cache
// Field widths, request kinds, default geometry and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fpwb_pkg;

  localparam int ADDR_W = 12;
  localparam int DATA_W = 8;
  localparam int KIND_W = 2;

  localparam int DEF_PAGE_BYTES  = 64;
  localparam int DEF_FLASH_BYTES = 4096;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  // Request kinds.
  localparam logic [KIND_W-1:0] REQ_READ   = 2'd0;
  localparam logic [KIND_W-1:0] REQ_WRITE  = 2'd1;
  localparam logic [KIND_W-1:0] REQ_FLUSH  = 2'd2;
  localparam logic [KIND_W-1:0] REQ_DIRECT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;         // latch a new request, clear the result
    logic cnt_clr;         // reset the byte counter
    logic cnt_inc;         // advance the byte counter
    logic clear_wr;        // reset sweep: erase flash byte at the counter
    logic erase_wr;        // erase one byte of the cached page
    logic prog;            // program pipeline step
    logic load;            // load pipeline step
    logic dread;           // direct flash read at the request address
    logic acc_write;       // apply a cached write to the buffer
    logic set_read_buf;    // take read data from the buffer
    logic set_read_flash;  // take read data from the flash array
    logic mark_loaded;
    logic mark_erased;
    logic mark_programmed;
    logic drop;            // forget the cached page
    logic finish;          // result complete, strobe it next cycle
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              hit;
    logic              modified;
    logic              erase_needed;
    logic              page_last;   // counter at the last byte of a page
    logic              page_end;    // counter one past the last byte
    logic              flash_last;  // counter at the last flash byte
  } status_t;

endpackage

// ----- design/fpwb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/fpwb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_ctrl: request sequencer
// Steps each request through address reduction, then write-back, page load,
// buffer access or a direct read as needed, one command group per cycle.
// ----------------------------------------------------------------------------
module fpwb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fpwb_pkg::status_t status,
  output fpwb_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_Q1    = 4'd2;
  localparam logic [3:0] S_R1    = 4'd3;
  localparam logic [3:0] S_Q2    = 4'd4;
  localparam logic [3:0] S_R2    = 4'd5;
  localparam logic [3:0] S_DISP  = 4'd6;
  localparam logic [3:0] S_ERASE = 4'd7;
  localparam logic [3:0] S_PROG  = 4'd8;
  localparam logic [3:0] S_LOAD  = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_ACC2  = 4'd11;
  localparam logic [3:0] S_DRD   = 4'd12;

  logic [3:0] state, state_next;
  logic       miss, miss_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      miss  <= 1'b0;
    end else begin
      state <= state_next;
      miss  <= miss_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    miss_next  = miss;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (status.flash_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_Q1;
        end
      end
      S_Q1: state_next = S_R1;
      S_R1: state_next = S_Q2;
      S_Q2: state_next = S_R2;
      S_R2: state_next = S_DISP;
      S_DISP: begin
        cmd.cnt_clr = 1'b1;
        miss_next   = 1'b0;
        case (status.kind)
          fpwb_pkg::REQ_DIRECT: begin
            cmd.dread  = 1'b1;
            state_next = S_DRD;
          end
          fpwb_pkg::REQ_FLUSH: begin
            if (status.modified) begin
              state_next = status.erase_needed ? S_ERASE : S_PROG;
            end else begin
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end
          end
          fpwb_pkg::REQ_READ, fpwb_pkg::REQ_WRITE: begin
            if (status.hit) begin
              state_next = S_ACC;
            end else if (status.modified) begin
              miss_next  = 1'b1;
              state_next = status.erase_needed ? S_ERASE : S_PROG;
            end else begin
              cmd.drop   = 1'b1;
              state_next = S_LOAD;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_ERASE: begin
        cmd.erase_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (status.page_last) begin
          cmd.mark_erased = 1'b1;
          cmd.cnt_clr     = 1'b1;
          state_next      = S_PROG;
        end
      end
      S_PROG: begin
        cmd.prog    = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.page_end) begin
          cmd.mark_programmed = 1'b1;
          cmd.cnt_clr         = 1'b1;
          if (miss) begin
            cmd.drop   = 1'b1;
            state_next = S_LOAD;
          end else begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        cmd.load    = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.page_end) begin
          cmd.mark_loaded = 1'b1;
          cmd.cnt_clr     = 1'b1;
          state_next      = S_ACC;
        end
      end
      S_ACC: state_next = S_ACC2;
      S_ACC2: begin
        if (status.kind == fpwb_pkg::REQ_READ) begin
          cmd.set_read_buf = 1'b1;
        end else begin
          cmd.acc_write = 1'b1;
        end
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_DRD: begin
        cmd.set_read_flash = 1'b1;
        cmd.finish         = 1'b1;
        state_next         = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/fpwb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_datapath: request registers, address reduction, cache state and RAMs
// Holds the flash array and the page buffer and carries out the byte-wide
// sweeps that the controller commands.
// ----------------------------------------------------------------------------
module fpwb_datapath #(
  parameter int PAGE_BYTES  = fpwb_pkg::DEF_PAGE_BYTES,
  parameter int FLASH_BYTES = fpwb_pkg::DEF_FLASH_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fpwb_pkg::cmd_t                      cmd,
  output fpwb_pkg::status_t                   status,
  input  logic [fpwb_pkg::KIND_W-1:0]         req_type,
  input  logic [fpwb_pkg::ADDR_W-1:0]         address,
  input  logic [fpwb_pkg::DATA_W-1:0]         write_data,
  output logic                                done,
  output logic [fpwb_pkg::DATA_W-1:0]         read_data,
  output logic                                page_loaded,
  output logic                                page_erased,
  output logic                                page_programmed
);

  localparam int AW   = fpwb_pkg::ADDR_W;
  localparam int DW   = fpwb_pkg::DATA_W;
  localparam int FAW  = $clog2(FLASH_BYTES);
  localparam int PAW  = $clog2(PAGE_BYTES);
  localparam int MAXB = (FLASH_BYTES > PAGE_BYTES) ? FLASH_BYTES : PAGE_BYTES;
  localparam int CW   = $clog2(MAXB + 1);
  localparam int SUMW = ((AW > CW) ? AW : CW) + 1;

  // Constant division by reciprocal multiplication, exact for AW-bit values.
  localparam int SF   = AW + $clog2(FLASH_BYTES);
  localparam int MF   = ((1 << SF) + FLASH_BYTES - 1) / FLASH_BYTES;
  localparam int MFW  = $clog2(MF + 1);
  localparam int SP   = AW + $clog2(PAGE_BYTES);
  localparam int MP   = ((1 << SP) + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int MPW  = $clog2(MP + 1);
  localparam int FW   = $clog2(FLASH_BYTES + 1);
  localparam int PW   = $clog2(PAGE_BYTES + 1);

  logic [fpwb_pkg::KIND_W-1:0] req_kind;
  logic [AW-1:0]               req_addr;
  logic [DW-1:0]               req_wdata;

  logic [AW-1:0]  q_f, a_red, q_p, base;
  logic [PAW-1:0] off;
  logic [AW+MFW-1:0] qf_full;
  logic [AW+FW-1:0]  qf_prod;
  logic [AW+MPW-1:0] qp_full;
  logic [AW+PW-1:0]  qp_prod;

  logic [AW-1:0] cached_base;
  logic          loaded, modified, erase_needed;
  logic [CW-1:0] cnt;

  logic [CW-1:0]  prev_cnt;
  logic           prev_inr;
  logic [FAW-1:0] prev_faddr;

  logic [SUMW-1:0] sum_req, sum_wb, cur_sum, dir_sum;

  logic           fl_we;
  logic [FAW-1:0] fl_waddr, fl_raddr;
  logic [DW-1:0]  fl_wdata, fl_rdata;
  logic           bf_we;
  logic [PAW-1:0] bf_waddr, bf_raddr;
  logic [DW-1:0]  bf_wdata, bf_rdata;
  logic           wr_differs;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= req_type;
      req_addr  <= address;
      req_wdata <= write_data;
    end
  end

  // Address reduction: one multiply per cycle, registered after each.
  assign qf_full = (AW+MFW)'(req_addr) * (AW+MFW)'(MF);
  assign qf_prod = (AW+FW)'(q_f) * (AW+FW)'(FLASH_BYTES);
  assign qp_full = (AW+MPW)'(a_red) * (AW+MPW)'(MP);
  assign qp_prod = (AW+PW)'(q_p) * (AW+PW)'(PAGE_BYTES);

  always_ff @(posedge clk) begin
    q_f   <= AW'(qf_full >> SF);
    a_red <= req_addr - qf_prod[AW-1:0];
    q_p   <= AW'(qp_full >> SP);
    base  <= qp_prod[AW-1:0];
    off   <= PAW'(a_red - qp_prod[AW-1:0]);
  end

  assign sum_req = SUMW'(base) + SUMW'(cnt);
  assign sum_wb  = SUMW'(cached_base) + SUMW'(cnt);
  assign cur_sum = cmd.load ? sum_req : sum_wb;
  assign dir_sum = SUMW'(a_red);

  always_ff @(posedge clk) begin
    prev_cnt   <= cnt;
    prev_inr   <= (cur_sum < SUMW'(FLASH_BYTES));
    prev_faddr <= cur_sum[FAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end
  end

  // Flash array port selection.
  always_comb begin
    fl_we    = 1'b0;
    fl_waddr = prev_faddr;
    fl_wdata = fpwb_pkg::ERASED_BYTE;
    fl_raddr = sum_req[FAW-1:0];
    if (cmd.clear_wr) begin
      fl_we    = 1'b1;
      fl_waddr = cnt[FAW-1:0];
    end
    if (cmd.erase_wr) begin
      fl_we    = (sum_wb < SUMW'(FLASH_BYTES));
      fl_waddr = sum_wb[FAW-1:0];
    end
    if (cmd.prog) begin
      fl_raddr = sum_wb[FAW-1:0];
      fl_we    = prev_inr && (cnt != '0);
      fl_wdata = fl_rdata & bf_rdata;
    end
    if (cmd.dread) begin
      fl_raddr = dir_sum[FAW-1:0];
    end
  end

  // Page buffer port selection.
  assign wr_differs = (req_wdata != bf_rdata);
  assign bf_raddr   = cmd.prog ? cnt[PAW-1:0] : off;

  always_comb begin
    bf_we    = 1'b0;
    bf_waddr = off;
    bf_wdata = req_wdata;
    if (cmd.load) begin
      bf_we    = (cnt != '0);
      bf_waddr = prev_cnt[PAW-1:0];
      bf_wdata = prev_inr ? fl_rdata : fpwb_pkg::ERASED_BYTE;
    end
    if (cmd.acc_write) begin
      bf_we = wr_differs;
    end
  end

  fpwb_ram #(.WIDTH(DW), .DEPTH(FLASH_BYTES)) u_flash (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  fpwb_ram #(.WIDTH(DW), .DEPTH(PAGE_BYTES)) u_buf (
    .clk   (clk),
    .we    (bf_we),
    .waddr (bf_waddr),
    .wdata (bf_wdata),
    .raddr (bf_raddr),
    .rdata (bf_rdata)
  );

  // Cache bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      cached_base  <= '0;
      loaded       <= 1'b0;
      modified     <= 1'b0;
      erase_needed <= 1'b0;
    end else begin
      if (cmd.drop) begin
        loaded       <= 1'b0;
        modified     <= 1'b0;
        erase_needed <= 1'b0;
      end
      if (cmd.mark_loaded) begin
        cached_base <= base;
        loaded      <= 1'b1;
      end
      if (cmd.mark_erased) begin
        erase_needed <= 1'b0;
      end
      if (cmd.mark_programmed) begin
        modified <= 1'b0;
      end
      if (cmd.acc_write && wr_differs) begin
        modified <= 1'b1;
        if ((req_wdata & ~bf_rdata) != '0) begin
          erase_needed <= 1'b1;
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done            <= 1'b0;
      read_data       <= '0;
      page_loaded     <= 1'b0;
      page_erased     <= 1'b0;
      page_programmed <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.capture) begin
        read_data       <= '0;
        page_loaded     <= 1'b0;
        page_erased     <= 1'b0;
        page_programmed <= 1'b0;
      end
      if (cmd.set_read_buf) begin
        read_data <= bf_rdata;
      end
      if (cmd.set_read_flash) begin
        read_data <= fl_rdata;
      end
      if (cmd.mark_loaded) begin
        page_loaded <= 1'b1;
      end
      if (cmd.mark_erased) begin
        page_erased <= 1'b1;
      end
      if (cmd.mark_programmed) begin
        page_programmed <= 1'b1;
      end
    end
  end

  assign status.kind         = req_kind;
  assign status.hit          = loaded && (cached_base == base);
  assign status.modified     = modified;
  assign status.erase_needed = erase_needed;
  assign status.page_last    = (cnt == CW'(PAGE_BYTES - 1));
  assign status.page_end     = (cnt == CW'(PAGE_BYTES));
  assign status.flash_last   = (cnt == CW'(FLASH_BYTES - 1));

endmodule

// ----- design/flash_page_write_back_cache_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_page_write_back_cache_top: single-page write-back flash cache
// A byte-wide flash array with a one-page write-back buffer in front of it,
// serving cached reads and writes, flushes and direct flash reads.
// ----------------------------------------------------------------------------
// Requests are taken one at a time: a beat is accepted when start is high and
// busy is low, and its single result is shown for exactly one cycle with done
// high. The receiver cannot stall, so it must take the result in that cycle.
// After reset the block first erases the whole flash array to 0xFF, one byte
// a cycle, holding busy high until the sweep is through. Every request then
// begins with the address reduction (modulo the array size, then split into
// page base and offset): a registered multiply for the quotient by the array
// size, one for the remainder, then one each for the page number and the
// page base. A miss loads the new page through the single flash read port;
// when the old page is dirty it is first written back by programming, with
// an erase before that when a bit had to return from 0 to 1. A dirty flush
// performs the same write-back, a clean flush none. busy falls in the cycle
// in which done is high, so the next request can be accepted there.
// ----------------------------------------------------------------------------
module flash_page_write_back_cache_top #(
  parameter int PAGE_BYTES  = fpwb_pkg::DEF_PAGE_BYTES,
  parameter int FLASH_BYTES = fpwb_pkg::DEF_FLASH_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [fpwb_pkg::KIND_W-1:0] req_type,
  input  logic [fpwb_pkg::ADDR_W-1:0] address,
  input  logic [fpwb_pkg::DATA_W-1:0] write_data,
  output logic                        done,
  output logic [fpwb_pkg::DATA_W-1:0] read_data,
  output logic                        page_loaded,
  output logic                        page_erased,
  output logic                        page_programmed
);

  // The controller sequences each request; the datapath holds both memories
  // and all cache state, and reports back what the controller needs to
  // branch on.
  fpwb_pkg::cmd_t    cmd;
  fpwb_pkg::status_t status;

  fpwb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // The result flags live in the datapath and are cleared when a request is
  // taken, so they are stable from the done cycle until the next beat.
  fpwb_datapath #(
    .PAGE_BYTES  (PAGE_BYTES),
    .FLASH_BYTES (FLASH_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_type        (req_type),
    .address         (address),
    .write_data      (write_data),
    .done            (done),
    .read_data       (read_data),
    .page_loaded     (page_loaded),
    .page_erased     (page_erased),
    .page_programmed (page_programmed)
  );

endmodule

// ----- design/fpwb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_checker: port-level checks for the flash page write-back cache
// Watches the top level's ports; attached by the bind statement below.
// ----------------------------------------------------------------------------
module fpwb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic page_erased,
  input logic page_programmed
);

  // A result is only presented once the block is free again.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  // Accepting a beat makes the block busy, with no result strobed at once.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done)) else $error("accepted beat not held");

  // The result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");

  // An erase is always followed by programming within the same request.
  a_erase_prog: assert property (@(posedge clk) disable iff (rst)
    (done && page_erased) |-> page_programmed) else $error("erase without program");

endmodule

bind flash_page_write_back_cache_top fpwb_checker u_fpwb_checker (.*);

// ----- tb/tb_flash_page_write_back_cache_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flash_page_write_back_cache_top: self-checking bench for the page cache
// Drives cached reads, cached writes, flushes and direct flash reads into the
// block, keeps its own copy of the flash array and of the page buffer, and
// checks every result beat against the outcome predicted from that copy.
// ----------------------------------------------------------------------------
module tb_flash_page_write_back_cache_top;

  // Geometry of the instance under test. The bench uses the block's defaults.
  localparam int PAGE_BYTES  = fpwb_pkg::DEF_PAGE_BYTES;
  localparam int FLASH_BYTES = fpwb_pkg::DEF_FLASH_BYTES;
  localparam int PAGE_COUNT  = FLASH_BYTES / PAGE_BYTES;

  localparam int CLK_PERIOD      = 8;
  localparam int RANDOM_ACCESSES = 1520;
  // The last requests go in back to back, with no gaps from the sender.
  localparam int CALM_TAIL       = 150;
  // The reset sweep holds busy while it erases the whole array, and a miss on a
  // dirty page that needs erasing is the longest request; this allows for both
  // several times over.
  localparam int STALL_LIMIT     = 4 * FLASH_BYTES + 4000;
  localparam int DRAIN_CYCLES    = 400;
  localparam int MAX_PRINTED     = 40;

  // One request beat as the sender presents it.
  typedef struct packed {
    logic [fpwb_pkg::KIND_W-1:0] kind;
    logic [fpwb_pkg::ADDR_W-1:0] addr;
    logic [fpwb_pkg::DATA_W-1:0] data;
  } access_t;

  // What a single request is expected to report.
  typedef struct packed {
    logic [fpwb_pkg::DATA_W-1:0] rdata;
    logic                        loaded;
    logic                        erased;
    logic                        programmed;
  } outcome_t;

  logic                        clk        = 1'b0;
  logic                        rst        = 1'b1;
  logic                        start      = 1'b0;
  logic [fpwb_pkg::KIND_W-1:0] req_type   = fpwb_pkg::REQ_READ;
  logic [fpwb_pkg::ADDR_W-1:0] address    = '0;
  logic [fpwb_pkg::DATA_W-1:0] write_data = '0;
  logic                        busy;
  logic                        done;
  logic [fpwb_pkg::DATA_W-1:0] read_data;
  logic                        page_loaded;
  logic                        page_erased;
  logic                        page_programmed;

  access_t  access_q[$];   // requests still to be offered to the block
  outcome_t outcome_q[$];  // outcomes of accepted requests, oldest first

  logic took_beat   = 1'b0;  // the request on the ports was accepted last edge
  int   gap_left    = 0;     // idle cycles still owed by the sender
  int   quiet_count = 0;     // cycles since the last beat on either side
  int   fault_count = 0;

  // Our own picture of the block's storage, kept in step with every accepted
  // request.
  logic [fpwb_pkg::DATA_W-1:0] flash_mirror[FLASH_BYTES];
  logic [fpwb_pkg::DATA_W-1:0] page_mirror[PAGE_BYTES];
  int                          mirror_base   = 0;
  logic                        mirror_loaded = 1'b0;
  logic                        mirror_dirty  = 1'b0;
  logic                        mirror_erase  = 1'b0;

  flash_page_write_back_cache_top u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .address         (address),
    .write_data      (write_data),
    .done            (done),
    .read_data       (read_data),
    .page_loaded     (page_loaded),
    .page_erased     (page_erased),
    .page_programmed (page_programmed)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Write the buffered page back to the flash copy. The page is erased first
  // only when some buffered bit has gone from 0 to 1 since it was loaded;
  // programming can only clear bits, so each flash byte becomes itself AND
  // the buffered byte.
  function automatic void write_back_mirror(inout outcome_t res);
    int a;
    if (mirror_erase) begin
      for (int i = 0; i < PAGE_BYTES; i++) begin
        a = mirror_base + i;
        if (a < FLASH_BYTES) flash_mirror[a] = fpwb_pkg::ERASED_BYTE;
      end
      mirror_erase = 1'b0;
      res.erased   = 1'b1;
    end
    for (int i = 0; i < PAGE_BYTES; i++) begin
      a = mirror_base + i;
      if (a < FLASH_BYTES) flash_mirror[a] = flash_mirror[a] & page_mirror[i];
    end
    mirror_dirty   = 1'b0;
    res.programmed = 1'b1;
  endfunction

  // Make the page holding addr resident and return the offset within it. A
  // different resident page is written back first if it is dirty. Bytes past
  // the end of the array would load as erased.
  function automatic int bring_in_page(int addr, inout outcome_t res);
    int offset;
    int base;
    offset = addr % PAGE_BYTES;
    base   = addr - offset;
    if (mirror_loaded && mirror_base != base) begin
      if (mirror_dirty) write_back_mirror(res);
      mirror_loaded = 1'b0;
      mirror_dirty  = 1'b0;
      mirror_erase  = 1'b0;
    end
    if (!mirror_loaded) begin
      mirror_base = base;
      for (int i = 0; i < PAGE_BYTES; i++) begin
        page_mirror[i] = (base + i < FLASH_BYTES) ? flash_mirror[base + i]
                                                  : fpwb_pkg::ERASED_BYTE;
      end
      mirror_loaded = 1'b1;
      res.loaded    = 1'b1;
    end
    return offset;
  endfunction

  // Apply one accepted request to the mirror and return what the block must
  // report for it.
  function automatic outcome_t predict_outcome(access_t acc);
    outcome_t                    res;
    int                          addr;
    int                          offset;
    logic [fpwb_pkg::DATA_W-1:0] raised;
    res  = '0;
    addr = int'(acc.addr) % FLASH_BYTES;
    case (acc.kind)
      fpwb_pkg::REQ_READ: begin
        offset    = bring_in_page(addr, res);
        res.rdata = page_mirror[offset];
      end
      fpwb_pkg::REQ_WRITE: begin
        offset = bring_in_page(addr, res);
        // Writing the value already buffered leaves the dirty state unchanged.
        if (acc.data != page_mirror[offset]) begin
          raised = acc.data & ~page_mirror[offset];
          if (raised != '0) mirror_erase = 1'b1;
          page_mirror[offset] = acc.data;
          mirror_dirty        = 1'b1;
        end
      end
      fpwb_pkg::REQ_FLUSH: begin
        // A clean flush does nothing; either way the page stays resident.
        if (mirror_dirty) write_back_mirror(res);
      end
      fpwb_pkg::REQ_DIRECT: begin
        // Straight from the flash copy, so a dirty buffer is not seen.
        res.rdata = (addr < FLASH_BYTES) ? flash_mirror[addr] : fpwb_pkg::ERASED_BYTE;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (fault_count < MAX_PRINTED) begin
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    fault_count++;
  endtask

  task automatic queue_access(logic [fpwb_pkg::KIND_W-1:0] kind, int addr, int data);
    access_t acc;
    acc.kind = kind;
    acc.addr = fpwb_pkg::ADDR_W'(addr);
    acc.data = fpwb_pkg::DATA_W'(data);
    access_q.push_back(acc);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents one request at a time, holding start high until the
  // block takes the beat. All inputs change on the falling edge. Between
  // requests the sender now and then idles with start low, except over the
  // last stretch of the run.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    access_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_beat) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (access_q.size() != 0) begin
        nxt        = access_q.pop_front();
        req_type   <= nxt.kind;
        address    <= nxt.addr;
        write_data <= nxt.data;
        start      <= 1'b1;
        if (access_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(1, 10);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on each rising edge, first check a result beat against the
  // oldest outstanding outcome, then record a newly accepted request. The
  // order matters because a request may be taken in the very cycle in which
  // the previous result is strobed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    outcome_t want;
    access_t  acc;
    if (rst) begin
      took_beat <= 1'b0;
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result beat with no request outstanding", read_data, 0);
        end else begin
          want = outcome_q.pop_front();
          if (read_data !== want.rdata) begin
            report_mismatch("read_data", read_data, want.rdata);
          end
          if (page_loaded !== want.loaded) begin
            report_mismatch("page_loaded", page_loaded, want.loaded);
          end
          if (page_erased !== want.erased) begin
            report_mismatch("page_erased", page_erased, want.erased);
          end
          if (page_programmed !== want.programmed) begin
            report_mismatch("page_programmed", page_programmed, want.programmed);
          end
        end
      end
      if (start && !busy) begin
        acc.kind = req_type;
        acc.addr = address;
        acc.data = write_data;
        outcome_q.push_back(predict_outcome(acc));
      end
      took_beat <= start && !busy;
    end
  end

  // Watchdog: a run that goes this long without a beat on either side has
  // hung.
  always @(posedge clk) begin : watchdog
    if (rst || done || (start && !busy)) begin
      quiet_count <= 0;
    end else if (quiet_count >= STALL_LIMIT) begin
      $display("flash_page_write_back_cache_top: mismatch");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin : run_test
    int                          cur_page;
    int                          hot_page[4];
    int                          addr;
    int                          pick;
    int                          data;
    logic [fpwb_pkg::KIND_W-1:0] kind;

    foreach (flash_mirror[i]) flash_mirror[i] = fpwb_pkg::ERASED_BYTE;
    foreach (page_mirror[i]) page_mirror[i] = '0;

    // Directed part. After reset the whole array reads as erased.
    queue_access(fpwb_pkg::REQ_DIRECT, 0, 8'h00);
    queue_access(fpwb_pkg::REQ_DIRECT, FLASH_BYTES - 1, 8'hFF);
    // Flush with nothing resident: all flags stay low.
    queue_access(fpwb_pkg::REQ_FLUSH, 0, 8'h00);
    // First cached read loads page 0.
    queue_access(fpwb_pkg::REQ_READ, 0, 8'h00);
    // Writing the byte already held marks nothing.
    queue_access(fpwb_pkg::REQ_WRITE, 0, 8'hFF);
    // Clearing bits only: the later write-back programs without erasing.
    queue_access(fpwb_pkg::REQ_WRITE, 1, 8'h00);
    // The page is dirty, yet a direct read still sees the old flash byte.
    queue_access(fpwb_pkg::REQ_DIRECT, 1, 8'h00);
    queue_access(fpwb_pkg::REQ_FLUSH, 0, 8'h00);
    // A second flush finds the page clean, and the page is still resident.
    queue_access(fpwb_pkg::REQ_FLUSH, 0, 8'h00);
    queue_access(fpwb_pkg::REQ_READ, 1, 8'h00);
    // A bit going back from 0 to 1 forces an erase at write-back.
    queue_access(fpwb_pkg::REQ_WRITE, 1, 8'hFF);
    queue_access(fpwb_pkg::REQ_WRITE, PAGE_BYTES - 1, 8'hA5);
    // Miss on the top page: erase, program, then load.
    queue_access(fpwb_pkg::REQ_READ, FLASH_BYTES - 1, 8'h00);
    queue_access(fpwb_pkg::REQ_DIRECT, 1, 8'h00);
    queue_access(fpwb_pkg::REQ_DIRECT, PAGE_BYTES - 1, 8'h00);
    queue_access(fpwb_pkg::REQ_WRITE, FLASH_BYTES - 1, 8'h5A);
    queue_access(fpwb_pkg::REQ_WRITE, FLASH_BYTES - PAGE_BYTES, 8'h00);
    // Miss with a dirty page that needs no erase.
    queue_access(fpwb_pkg::REQ_READ, PAGE_BYTES, 8'h00);
    queue_access(fpwb_pkg::REQ_WRITE, PAGE_BYTES, 8'h00);
    queue_access(fpwb_pkg::REQ_READ, PAGE_BYTES, 8'h00);
    // Write miss: write-back and load within one request.
    queue_access(fpwb_pkg::REQ_WRITE, FLASH_BYTES / 2, 8'h81);
    queue_access(fpwb_pkg::REQ_FLUSH, FLASH_BYTES - 1, 8'hFF);
    queue_access(fpwb_pkg::REQ_DIRECT, FLASH_BYTES - 1, 8'h00);
    queue_access(fpwb_pkg::REQ_DIRECT, FLASH_BYTES / 2, 8'h00);
    queue_access(fpwb_pkg::REQ_DIRECT, FLASH_BYTES - PAGE_BYTES, 8'h00);

    // Random part. Most requests stay on the current page or move among a
    // few busy pages, so that hits, dirty pages and both kinds of write-back
    // keep turning up; now and then a request strays anywhere in the array.
    foreach (hot_page[i]) hot_page[i] = $urandom_range(0, PAGE_COUNT - 1);
    cur_page = hot_page[0];
    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      if ($urandom_range(0, 49) == 0) begin
        hot_page[$urandom_range(0, 3)] = $urandom_range(0, PAGE_COUNT - 1);
      end
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
        cur_page = $urandom_range(0, PAGE_COUNT - 1);
      end else if (pick >= 70) begin
        cur_page = hot_page[$urandom_range(0, 3)];
      end
      addr = cur_page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);

      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        kind = fpwb_pkg::REQ_READ;
      end else if (pick < 70) begin
        kind = fpwb_pkg::REQ_WRITE;
      end else if (pick < 80) begin
        kind = fpwb_pkg::REQ_FLUSH;
      end else begin
        kind = fpwb_pkg::REQ_DIRECT;
      end

      // Erased and cleared bytes are common in flash, and an AND of two random
      // bytes tends to have few bits set, which makes an erase less likely.
      case ($urandom_range(0, 3))
        0:       data = 8'hFF;
        1:       data = 8'h00;
        2:       data = $urandom_range(0, 255);
        default: data = $urandom_range(0, 255) & $urandom_range(0, 255);
      endcase

      queue_access(kind, addr, data);
      // Repeating a write gives the unchanged-value case.
      if (kind == fpwb_pkg::REQ_WRITE && $urandom_range(0, 4) == 0) begin
        queue_access(kind, addr, data);
      end
    end

    // Reset is released on a falling edge and never raised again.
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (access_q.size() != 0 || start || outcome_q.size() != 0) begin
      @(posedge clk);
    end
    // Let any stray result beat show itself before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("flash_page_write_back_cache_top: match");
    end else begin
      $display("flash_page_write_back_cache_top: mismatch");
    end
    $finish;
  end

endmodule
